/* rtl/assert_macros.svh */
// Assertion macros for the concurrent checks of the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPL(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
	else $error("assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

/* rtl/bmc_pkg.sv */
// Shared types and constants for the batch median collector.
`timescale 1ns / 1ps
`default_nettype none

package bmc_pkg;

	localparam int VAL_W         = 16;
	localparam int CNT_W         = 7;
	localparam int MAX_BATCH_DEF = 64;

	localparam logic [CNT_W-1:0] BATCH_SIZE_RST = 7'd8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CMP,
		ST_FILL,
		ST_CHECK,
		ST_MRD_LO,
		ST_MRD_HI,
		ST_MSUM,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_rd;
		logic shift_wr;
		logic fill_wr;
		logic commit;
		logic med_rd_lo;
		logic med_rd_hi;
		logic med_sum;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic take_zero;
		logic pos_zero;
		logic gt;
		logic cnt_last;
		logic full;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/batch_median_collector_unit.sv */
// Top level of the batch median collector: controller and datapath joined.
//
//  channel   direction  handshake              payload
//  in        in         in_valid / in_ready    value, repeat_req
//  out       out        out_valid / out_ready  batch_done, median, fill_level, dropped
//  cfg       in         cfg_wr_en              cfg_wr_data (batch size)
//
// One word is taken at a time. For each word the controller scans down past every stored
// entry above the new value, shifting each up by the number of copies kept, then writes
// the copies; a word that completes a batch also reads the two middle entries for the
// median. The single read and single write port of the sorted store set this order.
// Reset clears the fill count, the batch size (to 8) and the output valid flag;
// the store itself is not cleared, as entries are only read after being written.
// A stalled output holds its word and the finished next word waits until it leaves.
`timescale 1ns / 1ps
`default_nettype none

module batch_median_collector_unit #(
	parameter int MAX_BATCH = bmc_pkg::MAX_BATCH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [bmc_pkg::CNT_W-1:0]   cfg_wr_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [bmc_pkg::VAL_W-1:0]   value,
	input  wire logic [bmc_pkg::CNT_W-1:0]   repeat_req,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             batch_done,
	output logic [bmc_pkg::VAL_W-1:0]        median,
	output logic [bmc_pkg::CNT_W-1:0]        fill_level,
	output logic [bmc_pkg::CNT_W-1:0]        dropped
);
	import bmc_pkg::*;

	`include "assert_macros.svh"

	cmd_t cmd;
	sts_t sts;

	// The controller steps through scan, shift, fill and median reads.
	bmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// The datapath owns the sorted store, the counters and the result register.
	bmc_dpath #(
		.MAX_BATCH (MAX_BATCH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.value       (value),
		.repeat_req  (repeat_req),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.batch_done  (batch_done),
		.median      (median),
		.fill_level  (fill_level),
		.dropped     (dropped)
	);

	// Only one word is in work at a time: accepting one closes the input.
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)
	// A word that does not close a batch reports a zero median.
	`ASSERT_IMPL(a_med_zero, clk, arst_n, out_valid && !batch_done, median == '0)
	// A completed batch always leaves the store empty.
	`ASSERT_IMPL(a_done_empty, clk, arst_n, out_valid && batch_done, fill_level == '0)

endmodule

`default_nettype wire

/* rtl/bmc_ctrl.sv */
// Controller state machine of the batch median collector.
`timescale 1ns / 1ps
`default_nettype none

module bmc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output bmc_pkg::cmd_t      cmd,
	input  wire bmc_pkg::sts_t sts
);
	import bmc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// Nothing to store goes straight to the completion check.
				if (sts.take_zero) begin
					state_d = ST_CHECK;
				end else if (sts.pos_zero) begin
					state_d = ST_FILL;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = ST_CMP;
				end
			end
			ST_CMP: begin
				if (sts.gt) begin
					cmd.shift_wr = 1'b1;
					state_d      = ST_SCAN;
				end else begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill_wr = 1'b1;
				if (sts.cnt_last) begin
					cmd.commit = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.full) begin
					cmd.med_rd_lo = 1'b1;
					state_d       = ST_MRD_LO;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_MRD_LO: begin
				cmd.med_rd_hi = 1'b1;
				state_d       = ST_MRD_HI;
			end
			ST_MRD_HI: begin
				state_d = ST_MSUM;
			end
			ST_MSUM: begin
				cmd.med_sum = 1'b1;
				state_d     = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/bmc_dpath.sv */
// Datapath of the batch median collector: sorted store, counters and result register.
`timescale 1ns / 1ps
`default_nettype none

module bmc_dpath #(
	parameter int MAX_BATCH = bmc_pkg::MAX_BATCH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire bmc_pkg::cmd_t               cmd,
	output bmc_pkg::sts_t                    sts,
	input  wire logic                        cfg_wr_en,
	input  wire logic [bmc_pkg::CNT_W-1:0]   cfg_wr_data,
	input  wire logic [bmc_pkg::VAL_W-1:0]   value,
	input  wire logic [bmc_pkg::CNT_W-1:0]   repeat_req,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             batch_done,
	output logic [bmc_pkg::VAL_W-1:0]        median,
	output logic [bmc_pkg::CNT_W-1:0]        fill_level,
	output logic [bmc_pkg::CNT_W-1:0]        dropped
);
	import bmc_pkg::*;

	localparam int AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

	logic [VAL_W-1:0] mem [MAX_BATCH];

	logic [CNT_W-1:0] batch_size_q;
	logic [CNT_W-1:0] fill_q;
	logic             out_valid_q;

	logic [VAL_W-1:0] val_q;
	logic [CNT_W-1:0] take_q;
	logic [CNT_W-1:0] drop_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] lim_q;
	logic [VAL_W-1:0] rd_data_q;
	logic [VAL_W-1:0] a_q;
	logic [VAL_W-1:0] med_q;
	logic             done_q;

	logic             out_done_q;
	logic [VAL_W-1:0] out_med_q;
	logic [CNT_W-1:0] out_fill_q;
	logic [CNT_W-1:0] out_drop_q;

	logic [CNT_W-1:0] lim_now;
	logic [CNT_W-1:0] room_now;
	logic [CNT_W-1:0] take_now;
	logic [CNT_W-1:0] pos_dec;
	logic [VAL_W:0]   med_sum;

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;

	// Zero counts as one; anything above the store depth saturates.
	always_comb begin
		if (batch_size_q == '0) begin
			lim_now = CNT_W'(1);
		end else if (32'(batch_size_q) > MAX_BATCH) begin
			lim_now = CNT_W'(MAX_BATCH);
		end else begin
			lim_now = batch_size_q;
		end
		room_now = (fill_q < lim_now) ? (lim_now - fill_q) : '0;
		take_now = (repeat_req < room_now) ? repeat_req : room_now;
	end

	assign pos_dec = pos_q - CNT_W'(1);
	assign med_sum = {1'b0, a_q} + {1'b0, rd_data_q};

	// Write port: shifting an entry up by the copy count, or placing a copy.
	always_comb begin
		wr_en   = cmd.shift_wr | cmd.fill_wr;
		wr_addr = AW'(pos_q);
		wr_data = val_q;
		if (cmd.shift_wr) begin
			wr_addr = AW'(pos_dec + take_q);
			wr_data = rd_data_q;
		end
	end

	// Read port: scanning downwards, or fetching the two middle entries.
	always_comb begin
		rd_en   = cmd.scan_rd | cmd.med_rd_lo | cmd.med_rd_hi;
		rd_addr = AW'(pos_dec);
		if (cmd.med_rd_lo) begin
			rd_addr = AW'((lim_q - CNT_W'(1)) >> 1);
		end else if (cmd.med_rd_hi) begin
			rd_addr = AW'(lim_q >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_size_q <= BATCH_SIZE_RST;
			fill_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				batch_size_q <= cfg_wr_data;
			end
			if (cmd.commit) begin
				fill_q <= fill_q + take_q;
			end else if (cmd.emit && done_q) begin
				fill_q <= '0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q  <= value;
			take_q <= take_now;
			drop_q <= repeat_req - take_now;
			pos_q  <= fill_q;
			cnt_q  <= take_now;
			lim_q  <= lim_now;
			done_q <= 1'b0;
			med_q  <= '0;
		end
		if (cmd.shift_wr) begin
			pos_q <= pos_dec;
		end
		if (cmd.fill_wr) begin
			pos_q <= pos_q + CNT_W'(1);
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.med_rd_hi) begin
			a_q <= rd_data_q;
		end
		if (cmd.med_sum) begin
			med_q  <= med_sum[VAL_W:1];
			done_q <= 1'b1;
		end
		if (cmd.emit) begin
			out_done_q <= done_q;
			out_med_q  <= med_q;
			out_fill_q <= done_q ? '0 : fill_q;
			out_drop_q <= drop_q;
		end
	end

	always_comb begin
		sts.take_zero = (take_q == '0);
		sts.pos_zero  = (pos_q == '0);
		sts.gt        = (rd_data_q > val_q);
		sts.cnt_last  = (cnt_q == CNT_W'(1));
		sts.full      = (fill_q >= lim_q);
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign batch_done = out_done_q;
	assign median     = out_med_q;
	assign fill_level = out_fill_q;
	assign dropped    = out_drop_q;

endmodule

`default_nettype wire
